// ----- rtl/core/lraf_pkg.sv -----
// Shared types and constants for the link repeater activation machine.
// No dependencies; used by link_repeater_activation_fsm, lraf_loop_checker and tb_top.
package lraf_pkg;

   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 32;

   typedef enum logic [2:0] {
      MODE_SLEEP  = 3'd0,
      MODE_SCAN   = 3'd1,
      MODE_EVAL   = 3'd2,
      MODE_REPORT = 3'd3,
      MODE_REPEAT = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      SRC_IDLE = 2'd0,
      SRC_BASE = 2'd1,
      SRC_OWN  = 2'd2
   } source_type;

   // register indexes on the csr port
   localparam logic [CsrIdxW-1:0] REG_WEAK_THR     = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_STRONG_THR   = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_DEAD_CONFIRM = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_SCAN_SETTLE  = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_SAFETY_TMO   = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_MIN_ACTIVE   = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_RECOVERY     = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_REPORT_INT   = 3'd7;

   // reset values of the registers
   localparam logic signed [7:0] WEAK_THR_RST     = -8'sd75;
   localparam logic signed [7:0] STRONG_THR_RST   = -8'sd65;
   localparam logic [3:0]        DEAD_CONFIRM_RST = 4'd3;
   localparam logic [15:0]       SCAN_SETTLE_RST  = 16'd2000;
   localparam logic [31:0]       SAFETY_TMO_RST   = 32'd3600000;
   localparam logic [31:0]       MIN_ACTIVE_RST   = 32'd60000;
   localparam logic [31:0]       RECOVERY_RST     = 32'd30000;
   localparam logic [31:0]       REPORT_INT_RST   = 32'd10000;

   localparam logic signed [7:0] RSSI_NONE   = -8'sd128;
   localparam logic signed [7:0] RSSI_FLOOR  = -8'sd127;
   localparam logic [3:0]        DEAD_MAX    = 4'd15;
   localparam logic [6:0]        CONF_FULL   = 7'd100;
   localparam logic [6:0]        CONF_NEG    = 7'd95;
   localparam logic [6:0]        CONF_HI     = 7'd60;
   localparam logic [6:0]        CONF_LO     = 7'd30;
   localparam logic signed [9:0] CONF_OFFSET = 10'sd80;
   localparam logic signed [9:0] CONF_HI_S   = 10'sd60;
   localparam logic signed [9:0] CONF_LO_S   = 10'sd30;

endpackage

// ----- rtl/core/link_repeater_activation_fsm.sv -----
// Top level of the link repeater activation machine: state, csr bank, result register.
// Depends on lraf_pkg.
//
// One request word is one pass of the unit's control loop: time, command pulses,
// scan fingerprint summary and uplink RSSI. The machine steps sleep, scan,
// evaluate, report and repeater modes and returns one response word per request.
// Throughput is one word per clock while rsp_ready keeps taking words; the response
// appears in the cycle after the request is accepted, held in a single output
// register that takes a new word in the same cycle the previous one is taken. All
// mode logic is one level of 32-bit subtract-and-compare plus selection. Csr writes
// take effect at once and are meant to happen only while no word is in flight.
module link_repeater_activation_fsm
   import lraf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [31:0]         req_now_ms,
   input  logic                req_cmd_activate,
   input  logic                req_cmd_deactivate,
   input  logic [6:0]          req_cmd_confidence,
   input  logic                req_scan_ready,
   input  logic signed [7:0]   req_scan_avg_rssi,
   input  logic                req_uplink_up,
   input  logic signed [7:0]   req_uplink_rssi,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_mode,
   output logic                rsp_sleep_now,
   output logic                rsp_scan_start,
   output logic                rsp_send_fingerprint,
   output logic                rsp_ap_up,
   output logic signed [7:0]   rsp_ap_up_rssi,
   output logic                rsp_ap_down,
   output logic [1:0]          rsp_act_source,
   output logic [6:0]          rsp_act_confidence,

   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // csr bank
   logic signed [7:0] weak_thr_ff, strong_thr_ff;
   logic [3:0]        dead_confirm_ff;
   logic [15:0]       scan_settle_ff;
   logic [31:0]       safety_tmo_ff, min_active_ff, recovery_ff, report_int_ff;

   // machine state
   mode_type   mode_ff, mode_in;
   logic [31:0] scan_at_ff, scan_at_in;
   logic [31:0] repeat_at_ff, repeat_at_in;
   logic [31:0] recover_at_ff, recover_at_in;
   logic        recover_vld_ff, recover_vld_in;
   logic [31:0] resend_at_ff, resend_at_in;
   logic [3:0]  dead_cnt_ff, dead_cnt_in;
   logic        pend_act_ff, pend_act_in;
   logic        pend_deact_ff, pend_deact_in;
   source_type  source_ff, source_in;
   logic [6:0]  conf_ff, conf_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              sleep_now_ff, sleep_now_in;
   logic              scan_start_ff, scan_start_in;
   logic              send_fp_ff, send_fp_in;
   logic              ap_up_ff, ap_up_in;
   logic signed [7:0] ap_rssi_ff, ap_rssi_in;
   logic              ap_down_ff, ap_down_in;

   logic req_accept;

   // evaluation terms
   logic signed [7:0] uplink_lvl, worst;
   logic signed [9:0] conf_sum;
   logic              scan_none, link_none, scan_low, uplink_low;
   logic [3:0]        dead_inc;
   logic [6:0]        own_conf, cmd_conf;
   logic [31:0]       scan_el, repeat_el, resend_el, recover_el;
   logic              trigger;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         weak_thr_ff     <= WEAK_THR_RST;
         strong_thr_ff   <= STRONG_THR_RST;
         dead_confirm_ff <= DEAD_CONFIRM_RST;
         scan_settle_ff  <= SCAN_SETTLE_RST;
         safety_tmo_ff   <= SAFETY_TMO_RST;
         min_active_ff   <= MIN_ACTIVE_RST;
         recovery_ff     <= RECOVERY_RST;
         report_int_ff   <= REPORT_INT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_WEAK_THR:     weak_thr_ff     <= $signed(csr_wdata[7:0]);
            REG_STRONG_THR:   strong_thr_ff   <= $signed(csr_wdata[7:0]);
            REG_DEAD_CONFIRM: dead_confirm_ff <= csr_wdata[3:0];
            REG_SCAN_SETTLE:  scan_settle_ff  <= csr_wdata[15:0];
            REG_SAFETY_TMO:   safety_tmo_ff   <= csr_wdata;
            REG_MIN_ACTIVE:   min_active_ff   <= csr_wdata;
            REG_RECOVERY:     recovery_ff     <= csr_wdata;
            REG_REPORT_INT:   report_int_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      uplink_lvl = req_uplink_up ? req_uplink_rssi : RSSI_NONE;
      scan_none  = (req_scan_avg_rssi == RSSI_NONE);
      link_none  = (uplink_lvl == RSSI_NONE);
      scan_low   = !scan_none && (req_scan_avg_rssi < weak_thr_ff);
      uplink_low = uplink_lvl < weak_thr_ff;
      dead_inc   = (dead_cnt_ff == DEAD_MAX) ? DEAD_MAX : dead_cnt_ff + 4'd1;
      worst      = (uplink_low && (uplink_lvl > RSSI_FLOOR)) ? uplink_lvl : req_scan_avg_rssi;
      conf_sum   = {{2{worst[7]}}, worst} + CONF_OFFSET;
      if (conf_sum[9]) begin
         own_conf = CONF_NEG;
      end else if (conf_sum > CONF_HI_S) begin
         own_conf = CONF_HI;
      end else if (conf_sum < CONF_LO_S) begin
         own_conf = CONF_LO;
      end else begin
         own_conf = conf_sum[6:0];
      end
      cmd_conf  = ((req_cmd_confidence == 7'd0) || (req_cmd_confidence > CONF_FULL)) ?
                  CONF_FULL : req_cmd_confidence;
      scan_el    = req_now_ms - scan_at_ff;
      repeat_el  = req_now_ms - repeat_at_ff;
      resend_el  = req_now_ms - resend_at_ff;
      recover_el = req_now_ms - recover_at_ff;
   end

   always_comb begin
      mode_in        = mode_ff;
      scan_at_in     = scan_at_ff;
      repeat_at_in   = repeat_at_ff;
      recover_at_in  = recover_at_ff;
      recover_vld_in = recover_vld_ff;
      resend_at_in   = resend_at_ff;
      dead_cnt_in    = dead_cnt_ff;
      pend_act_in    = pend_act_ff || req_cmd_activate;
      pend_deact_in  = pend_deact_ff || req_cmd_deactivate;
      source_in      = req_cmd_activate ? SRC_BASE : source_ff;
      conf_in        = req_cmd_activate ? cmd_conf : conf_ff;
      sleep_now_in   = 1'b0;
      scan_start_in  = 1'b0;
      send_fp_in     = 1'b0;
      ap_up_in       = 1'b0;
      ap_rssi_in     = 8'sd0;
      ap_down_in     = 1'b0;
      trigger        = 1'b0;

      case (mode_ff)
         MODE_SLEEP: begin
            sleep_now_in  = 1'b1;
            scan_start_in = 1'b1;
            mode_in       = MODE_SCAN;
            scan_at_in    = req_now_ms;
         end
         MODE_SCAN: begin
            if (scan_el >= {16'd0, scan_settle_ff}) begin
               if (req_scan_ready) begin
                  mode_in = MODE_EVAL;
               end else begin
                  mode_in    = MODE_REPORT;
                  send_fp_in = 1'b1;
               end
            end
         end
         MODE_EVAL: begin
            if (!req_scan_ready) begin
               mode_in    = MODE_REPORT;
               send_fp_in = 1'b1;
            end else if (scan_none && !uplink_low) begin
               dead_cnt_in = 4'd0;
               mode_in     = MODE_REPORT;
               send_fp_in  = 1'b1;
            end else if (scan_none && link_none && (dead_inc < dead_confirm_ff)) begin
               // empty scan, not yet confirmed as a dead zone
               dead_cnt_in = dead_inc;
               mode_in     = MODE_REPORT;
               send_fp_in  = 1'b1;
            end else begin
               trigger = pend_act_in || scan_low || uplink_low ||
                         (scan_none && link_none) || (dead_cnt_ff >= dead_confirm_ff);
               dead_cnt_in = 4'd0;
               if (trigger) begin
                  if (!pend_act_in) begin
                     source_in = SRC_OWN;
                     conf_in   = own_conf;
                  end
                  pend_act_in    = 1'b0;
                  ap_up_in       = 1'b1;
                  ap_rssi_in     = req_scan_avg_rssi;
                  mode_in        = MODE_REPEAT;
                  repeat_at_in   = req_now_ms;
                  recover_vld_in = 1'b0;
                  recover_at_in  = 32'd0;
               end else begin
                  mode_in    = MODE_REPORT;
                  send_fp_in = 1'b1;
               end
            end
         end
         MODE_REPORT: begin
            mode_in = MODE_SLEEP;
            if (pend_deact_in) begin
               pend_deact_in  = 1'b0;
               ap_down_in     = 1'b1;
               repeat_at_in   = 32'd0;
               recover_vld_in = 1'b0;
               recover_at_in  = 32'd0;
            end
         end
         MODE_REPEAT: begin
            if ((repeat_el > safety_tmo_ff) || pend_deact_in) begin
               // safety timeout leaves a pending deactivate in place
               if (repeat_el <= safety_tmo_ff) begin
                  pend_deact_in = 1'b0;
               end
               mode_in        = MODE_SLEEP;
               ap_down_in     = 1'b1;
               repeat_at_in   = 32'd0;
               recover_vld_in = 1'b0;
               recover_at_in  = 32'd0;
            end else begin
               if (resend_el >= report_int_ff) begin
                  resend_at_in = req_now_ms;
                  send_fp_in   = req_scan_ready;
               end
               if (req_uplink_up && (repeat_el > min_active_ff)) begin
                  if (req_uplink_rssi >= strong_thr_ff) begin
                     if (!recover_vld_ff) begin
                        recover_vld_in = 1'b1;
                        recover_at_in  = req_now_ms;
                     end else if (recover_el > recovery_ff) begin
                        mode_in        = MODE_SLEEP;
                        ap_down_in     = 1'b1;
                        repeat_at_in   = 32'd0;
                        recover_vld_in = 1'b0;
                        recover_at_in  = 32'd0;
                     end
                  end else begin
                     recover_vld_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            mode_in = MODE_SLEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_SLEEP;
         scan_at_ff     <= 32'd0;
         repeat_at_ff   <= 32'd0;
         recover_at_ff  <= 32'd0;
         recover_vld_ff <= 1'b0;
         resend_at_ff   <= 32'd0;
         dead_cnt_ff    <= 4'd0;
         pend_act_ff    <= 1'b0;
         pend_deact_ff  <= 1'b0;
         source_ff      <= SRC_IDLE;
         conf_ff        <= CONF_FULL;
      end else if (req_accept) begin
         mode_ff        <= mode_in;
         scan_at_ff     <= scan_at_in;
         repeat_at_ff   <= repeat_at_in;
         recover_at_ff  <= recover_at_in;
         recover_vld_ff <= recover_vld_in;
         resend_at_ff   <= resend_at_in;
         dead_cnt_ff    <= dead_cnt_in;
         pend_act_ff    <= pend_act_in;
         pend_deact_ff  <= pend_deact_in;
         source_ff      <= source_in;
         conf_ff        <= conf_in;
      end
   end

   // hold the word until taken; reload in the same cycle it leaves
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sleep_now_ff  <= sleep_now_in;
         scan_start_ff <= scan_start_in;
         send_fp_ff    <= send_fp_in;
         ap_up_ff      <= ap_up_in;
         ap_rssi_ff    <= ap_rssi_in;
         ap_down_ff    <= ap_down_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mode             = mode_ff;
   assign rsp_sleep_now        = sleep_now_ff;
   assign rsp_scan_start       = scan_start_ff;
   assign rsp_send_fingerprint = send_fp_ff;
   assign rsp_ap_up            = ap_up_ff;
   assign rsp_ap_up_rssi       = ap_rssi_ff;
   assign rsp_ap_down          = ap_down_ff;
   assign rsp_act_source       = source_ff;
   assign rsp_act_confidence   = conf_ff;

   a_ap_up_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ap_up |-> rsp_mode == MODE_REPEAT)
      else $error("activation word without repeater mode");

   a_ap_down_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ap_down |-> rsp_mode == MODE_SLEEP && !rsp_ap_up)
      else $error("deactivation word not in sleep mode");

   a_recover_mode: assert property (@(posedge clock) disable iff (reset)
      recover_vld_ff |-> mode_ff == MODE_REPEAT)
      else $error("recovery tracking outside repeater mode");

   a_wake_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sleep_now |-> rsp_scan_start && rsp_mode == MODE_SCAN)
      else $error("wake word did not start a scan");

endmodule

// ----- dv/lraf_loop_checker.sv -----
// Checker for link_repeater_activation_fsm: follows csr writes, predicts one response
// word per accepted request word and compares responses in order, field by field.
// Depends on lraf_pkg.
`timescale 1ns / 100ps
module lraf_loop_checker
   import lraf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [31:0]         req_now_ms,
   input  logic                req_cmd_activate,
   input  logic                req_cmd_deactivate,
   input  logic [6:0]          req_cmd_confidence,
   input  logic                req_scan_ready,
   input  logic signed [7:0]   req_scan_avg_rssi,
   input  logic                req_uplink_up,
   input  logic signed [7:0]   req_uplink_rssi,

   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [2:0]          rsp_mode,
   input  logic                rsp_sleep_now,
   input  logic                rsp_scan_start,
   input  logic                rsp_send_fingerprint,
   input  logic                rsp_ap_up,
   input  logic signed [7:0]   rsp_ap_up_rssi,
   input  logic                rsp_ap_down,
   input  logic [1:0]          rsp_act_source,
   input  logic [6:0]          rsp_act_confidence,

   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,

   output int unsigned         mismatches,
   output int unsigned         in_flight
);

   typedef struct packed {
      logic [2:0]        mode;
      logic              sleep_now;
      logic              scan_start;
      logic              send_fp;
      logic              ap_up;
      logic signed [7:0] ap_rssi;
      logic              ap_down;
      logic [1:0]        source;
      logic [6:0]        conf;
   } loop_outcome_type;

   // machine state
   logic [2:0]  mode_q;
   logic [31:0] scan_t0, repeat_t0, recover_t0, resend_t0;
   logic        recover_ok, act_pending, deact_pending;
   logic [3:0]  dead_run;
   logic [1:0]  source_q;
   logic [6:0]  conf_q;

   // csr copy
   int          weak_thr, strong_thr;
   logic [3:0]  dead_need;
   logic [15:0] settle_ms;
   logic [31:0] safety_ms, min_active_ms, recover_ms, resend_ms;

   loop_outcome_type pending_outcomes[$];
   int unsigned      words_seen;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("lraf_loop_checker: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s: got %0h, want %0h",
                                   words_seen, name, got, want));
   endtask

   function automatic void apply_csr(input logic [CsrIdxW-1:0] idx,
                                     input logic [CsrDataW-1:0] data);
      case (idx)
         REG_WEAK_THR:     weak_thr      = $signed(data[7:0]);
         REG_STRONG_THR:   strong_thr    = $signed(data[7:0]);
         REG_DEAD_CONFIRM: dead_need     = data[3:0];
         REG_SCAN_SETTLE:  settle_ms     = data[15:0];
         REG_SAFETY_TMO:   safety_ms     = data;
         REG_MIN_ACTIVE:   min_active_ms = data;
         REG_RECOVERY:     recover_ms    = data;
         REG_REPORT_INT:   resend_ms     = data;
         default: ;
      endcase
   endfunction

   function automatic void drop_repeater();
      mode_q     = MODE_SLEEP;
      repeat_t0  = '0;
      recover_ok = 1'b0;
      recover_t0 = '0;
   endfunction

   function automatic loop_outcome_type advance_loop(
      input logic [31:0] now, input logic act, input logic deact, input logic [6:0] cconf,
      input logic ready, input logic signed [7:0] avg8, input logic up,
      input logic signed [7:0] ul8);
      loop_outcome_type o;
      int               avg, ul, link, worst, s;
      logic             scan_low, uplink_low, settled;
      logic [31:0]      since_scan, since_rep, since_resend, since_rec;
      o            = '0;
      avg          = avg8;
      ul           = ul8;
      since_scan   = now - scan_t0;
      since_rep    = now - repeat_t0;
      since_resend = now - resend_t0;
      since_rec    = now - recover_t0;
      settled      = 1'b0;

      // commands latch in every mode
      if (act) begin
         act_pending = 1'b1;
         source_q    = SRC_BASE;
         conf_q      = (cconf == 7'd0 || cconf > CONF_FULL) ? CONF_FULL : cconf;
      end
      if (deact) deact_pending = 1'b1;

      case (mode_q)
         MODE_SLEEP: begin
            o.sleep_now  = 1'b1;
            o.scan_start = 1'b1;
            mode_q       = MODE_SCAN;
            scan_t0      = now;
         end
         MODE_SCAN: begin
            if (since_scan >= {16'd0, settle_ms}) begin
               if (ready) begin
                  mode_q = MODE_EVAL;
               end else begin
                  mode_q    = MODE_REPORT;
                  o.send_fp = 1'b1;
               end
            end
         end
         MODE_EVAL: begin
            if (!ready) begin
               mode_q    = MODE_REPORT;
               o.send_fp = 1'b1;
            end else begin
               link       = up ? ul : RSSI_NONE;
               scan_low   = avg >= RSSI_FLOOR && avg < weak_thr;
               uplink_low = link < weak_thr;
               if (avg <= RSSI_NONE && link >= weak_thr) begin
                  // empty scan but a usable uplink: no dead zone
                  dead_run  = '0;
                  mode_q    = MODE_REPORT;
                  o.send_fp = 1'b1;
                  settled   = 1'b1;
               end else if (avg <= RSSI_NONE && link <= RSSI_NONE) begin
                  if (dead_run < DEAD_MAX) dead_run = dead_run + 4'd1;
                  if (dead_run < dead_need) begin
                     mode_q    = MODE_REPORT;
                     o.send_fp = 1'b1;
                     settled   = 1'b1;
                  end
               end
               if (!settled) begin
                  if (act_pending || scan_low || uplink_low || dead_run >= dead_need) begin
                     dead_run = '0;
                     if (!act_pending) begin
                        worst    = (uplink_low && link > RSSI_FLOOR) ? link : avg;
                        s        = worst + CONF_OFFSET;
                        source_q = SRC_OWN;
                        if (s < 0)              conf_q = CONF_NEG;
                        else if (s > CONF_HI_S) conf_q = CONF_HI;
                        else if (s < CONF_LO_S) conf_q = CONF_LO;
                        else                    conf_q = 7'(s);
                     end
                     act_pending = 1'b0;
                     o.ap_up     = 1'b1;
                     o.ap_rssi   = avg8;
                     mode_q      = MODE_REPEAT;
                     repeat_t0   = now;
                     recover_ok  = 1'b0;
                     recover_t0  = '0;
                  end else begin
                     dead_run  = '0;
                     mode_q    = MODE_REPORT;
                     o.send_fp = 1'b1;
                  end
               end
            end
         end
         MODE_REPORT: begin
            if (deact_pending) begin
               deact_pending = 1'b0;
               drop_repeater();
               o.ap_down     = 1'b1;
            end else begin
               mode_q = MODE_SLEEP;
            end
         end
         MODE_REPEAT: begin
            if (since_rep > safety_ms) begin
               drop_repeater();
               o.ap_down = 1'b1;
            end else if (deact_pending) begin
               deact_pending = 1'b0;
               drop_repeater();
               o.ap_down     = 1'b1;
            end else begin
               if (since_resend >= resend_ms) begin
                  resend_t0 = now;
                  if (ready) o.send_fp = 1'b1;
               end
               if (up && since_rep > min_active_ms) begin
                  if (ul >= strong_thr) begin
                     if (!recover_ok) begin
                        recover_ok = 1'b1;
                        recover_t0 = now;
                     end else if (since_rec > recover_ms) begin
                        drop_repeater();
                        o.ap_down = 1'b1;
                     end
                  end else begin
                     recover_ok = 1'b0;
                  end
               end
            end
         end
         default: mode_q = MODE_SLEEP;
      endcase

      o.mode   = mode_q;
      o.source = source_q;
      o.conf   = conf_q;
      return o;
   endfunction

   always @(posedge clock) begin : track
      loop_outcome_type want;
      if (reset) begin
         mode_q        = MODE_SLEEP;
         scan_t0       = '0;
         repeat_t0     = '0;
         recover_t0    = '0;
         resend_t0     = '0;
         recover_ok    = 1'b0;
         act_pending   = 1'b0;
         deact_pending = 1'b0;
         dead_run      = '0;
         source_q      = SRC_IDLE;
         conf_q        = CONF_FULL;
         weak_thr      = WEAK_THR_RST;
         strong_thr    = STRONG_THR_RST;
         dead_need     = DEAD_CONFIRM_RST;
         settle_ms     = SCAN_SETTLE_RST;
         safety_ms     = SAFETY_TMO_RST;
         min_active_ms = MIN_ACTIVE_RST;
         recover_ms    = RECOVERY_RST;
         resend_ms     = REPORT_INT_RST;
         pending_outcomes.delete();
         mismatches    = 0;
         words_seen    = 0;
      end else begin
         if (csr_we) apply_csr(csr_index, csr_wdata);
         // compare before predicting: a response never belongs to this edge's request
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("word %0d: response with no request outstanding",
                                         words_seen));
            end else begin
               want = pending_outcomes.pop_front();
               check_field("mode",             rsp_mode,             want.mode);
               check_field("sleep_now",        rsp_sleep_now,        want.sleep_now);
               check_field("scan_start",       rsp_scan_start,       want.scan_start);
               check_field("send_fingerprint", rsp_send_fingerprint, want.send_fp);
               check_field("ap_up",            rsp_ap_up,            want.ap_up);
               check_field("ap_up_rssi",       rsp_ap_up_rssi,       want.ap_rssi);
               check_field("ap_down",          rsp_ap_down,          want.ap_down);
               check_field("act_source",       rsp_act_source,       want.source);
               check_field("act_confidence",   rsp_act_confidence,   want.conf);
            end
         end
         if (req_valid && req_ready)
            pending_outcomes.push_back(advance_loop(req_now_ms, req_cmd_activate,
               req_cmd_deactivate, req_cmd_confidence, req_scan_ready, req_scan_avg_rssi,
               req_uplink_up, req_uplink_rssi));
      end
      in_flight = pending_outcomes.size();
   end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for link_repeater_activation_fsm: clock, reset, csr phases, request
// and response traffic with random gaps, watchdog and verdict.
// Depends on lraf_pkg, link_repeater_activation_fsm and lraf_loop_checker.
`timescale 1ns / 100ps
module tb_top;
   import lraf_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_AT     = 700;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      int          weak_lvl;
      int          strong_lvl;
      int unsigned dead;
      int unsigned settle;
      logic [31:0] safety;
      logic [31:0] min_active;
      logic [31:0] recovery;
      logic [31:0] resend;
   } csr_set_type;

   logic clock = 1'b0;
   logic reset;

   logic                req_valid, req_ready;
   logic [31:0]         req_now_ms;
   logic                req_cmd_activate, req_cmd_deactivate;
   logic [6:0]          req_cmd_confidence;
   logic                req_scan_ready;
   logic signed [7:0]   req_scan_avg_rssi;
   logic                req_uplink_up;
   logic signed [7:0]   req_uplink_rssi;

   logic                rsp_valid, rsp_ready;
   logic [2:0]          rsp_mode;
   logic                rsp_sleep_now, rsp_scan_start, rsp_send_fingerprint;
   logic                rsp_ap_up, rsp_ap_down;
   logic signed [7:0]   rsp_ap_up_rssi;
   logic [1:0]          rsp_act_source;
   logic [6:0]          rsp_act_confidence;

   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   int unsigned mismatches, in_flight;
   int          quiet_cycles;

   // stimulus context
   logic [31:0]       now_ms;
   int                weak_now, strong_now;
   int                tx_burst;
   logic              up_now;
   logic signed [7:0] uplink_now, scan_now;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   link_repeater_activation_fsm dut (.*);

   lraf_loop_checker u_check (.*);

   // no acceptance on either channel for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic draw_gap(inout int burst, output int gap);
      if (burst > 0) begin
         burst--;
         gap = 0;
      end else if ($urandom_range(0, 24) == 0) begin
         burst = $urandom_range(20, 60);
         gap   = 0;
      end else begin
         gap = $urandom_range(0, 13);
      end
   endtask

   function automatic logic signed [7:0] pick_rssi();
      int r, v;
      r = $urandom_range(0, 9);
      if (r < 2)      v = -128;
      else if (r < 3) v = -127;
      else if (r < 6) v = weak_now + int'($urandom_range(0, 4)) - 2;
      else if (r < 8) v = strong_now + int'($urandom_range(0, 4)) - 2;
      else            v = 0 - int'($urandom_range(0, 128));
      if (v < -128) v = -128;
      if (v > 0)    v = 0;
      return v[7:0];
   endfunction

   // hold the word until accepted; valid stays up across back-to-back words
   task automatic send_word(input logic [31:0] t, input logic act, input logic deact,
                            input logic [6:0] cconf, input logic ready,
                            input logic signed [7:0] avg, input logic up,
                            input logic signed [7:0] ul);
      int gap;
      draw_gap(tx_burst, gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_now_ms         <= t;
      req_cmd_activate   <= act;
      req_cmd_deactivate <= deact;
      req_cmd_confidence <= cconf;
      req_scan_ready     <= ready;
      req_scan_avg_rssi  <= avg;
      req_uplink_up      <= up;
      req_uplink_rssi    <= ul;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic put_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic run_phase(input csr_set_type cs, input int count, input int scale);
      int          r;
      logic [6:0]  cconf;
      req_valid <= 1'b0;
      // drain before touching the csr bank
      while (in_flight != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      put_csr(REG_WEAK_THR,     32'(cs.weak_lvl));
      put_csr(REG_STRONG_THR,   32'(cs.strong_lvl));
      put_csr(REG_DEAD_CONFIRM, 32'(cs.dead));
      put_csr(REG_SCAN_SETTLE,  32'(cs.settle));
      put_csr(REG_SAFETY_TMO,   cs.safety);
      put_csr(REG_MIN_ACTIVE,   cs.min_active);
      put_csr(REG_RECOVERY,     cs.recovery);
      put_csr(REG_REPORT_INT,   cs.resend);
      csr_we     <= 1'b0;
      weak_now   = cs.weak_lvl;
      strong_now = cs.strong_lvl;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 3)       now_ms = $urandom();
         else if (r < 40) now_ms = now_ms + $urandom_range(0, scale / 8);
         else             now_ms = now_ms + $urandom_range(0, 2 * scale);
         // uplink and scan level drift slowly so recovery and dead-zone runs can form
         if ($urandom_range(0, 3) == 0) begin
            up_now     = $urandom_range(0, 3) != 0;
            uplink_now = pick_rssi();
         end
         if ($urandom_range(0, 2) == 0) scan_now = pick_rssi();
         r = $urandom_range(0, 19);
         if (r < 3)      cconf = 7'd0;
         else if (r < 6) cconf = 7'($urandom_range(101, 127));
         else            cconf = 7'($urandom_range(1, 100));
         send_word(now_ms, $urandom_range(0, 19) == 0, $urandom_range(0, 29) == 0, cconf,
                   $urandom_range(0, 3) != 0, scan_now, up_now, uplink_now);
      end
   endtask

   // response side: random back-pressure plus one long hold-off
   initial begin : drain
      int gap, burst, taken;
      bit held;
      burst     = 0;
      taken     = 0;
      held      = 1'b0;
      rsp_ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         draw_gap(burst, gap);
         if (!held && taken == HOLD_AT) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      csr_set_type cs;
      int          scale;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_now_ms         = '0;
      req_cmd_activate   = 1'b0;
      req_cmd_deactivate = 1'b0;
      req_cmd_confidence = '0;
      req_scan_ready     = 1'b0;
      req_scan_avg_rssi  = '0;
      req_uplink_up      = 1'b0;
      req_uplink_rssi    = '0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      tx_burst           = 0;
      up_now             = 1'b1;
      uplink_now         = -8'sd60;
      scan_now           = -8'sd70;
      weak_now           = WEAK_THR_RST;
      strong_now         = STRONG_THR_RST;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk at reset settings
      send_word(0,     0, 0, 0,   0, -128, 0, -128);   // sleep, start scan
      send_word(100,   0, 0, 0,   0, -128, 0, -128);   // scan not settled
      send_word(2000,  0, 0, 0,   0, -128, 0, -128);   // settled, no fingerprint
      send_word(2001,  0, 1, 0,   0, -128, 0, -128);   // deactivate while reporting
      send_word(2002,  0, 0, 0,   0, -128, 0, -128);
      send_word(4002,  0, 0, 0,   1, -128, 0, -128);
      send_word(4003,  0, 0, 0,   1, -128, 0, -128);   // first empty evaluation
      send_word(4004,  0, 0, 0,   1, -128, 0, -128);
      send_word(4005,  0, 0, 0,   1, -128, 0, -128);
      send_word(6005,  0, 0, 0,   1, -128, 0, -128);
      send_word(6006,  0, 0, 0,   1, -128, 0, -128);
      send_word(6007,  0, 0, 0,   1, -128, 0, -128);
      send_word(6008,  0, 0, 0,   1, -128, 0, -128);
      send_word(8008,  0, 0, 0,   1, -128, 0, -128);
      send_word(8009,  0, 0, 0,   1, -128, 0, -128);   // dead zone confirmed
      send_word(8010,  0, 1, 0,   1, -128, 0, -128);   // deactivate the repeater
      send_word(8011,  1, 0, 0,   0, -128, 0, -128);   // activate, zero confidence
      send_word(10011, 0, 0, 0,   1, -90,  1, -40);
      send_word(10012, 0, 0, 0,   1, -90,  1, -40);    // activation from command
      send_word(70013, 1, 0, 127, 1, -90,  1, 0);      // resend, recovery starts
      send_word(100014, 0, 0, 0,  1, -90,  1, 0);      // recovered, repeater off
      send_word(32'hFFFF_FFFF, 0, 0, 0, 0, -1, 0, -1);  // scan start at top of time
      send_word(1999,  0, 0, 0,   0, -128, 0, -128);   // settle across the wrap
      send_word(2000,  0, 0, 0,   0, -128, 0, -128);
      now_ms = 2000;

      cs = '{-75, -65, 3, 2000, 32'd3600000, 32'd60000, 32'd30000, 32'd10000};
      run_phase(cs, 260, 3000);
      cs = '{-70, -60, 2, 500, 32'd40000, 32'd2000, 32'd3000, 32'd1500};
      run_phase(cs, 300, 800);
      cs = '{-128, -128, 0, 0, 32'd0, 32'd0, 32'd0, 32'd0};
      run_phase(cs, 200, 20);
      now_ms = 32'hFFFF_0000;
      cs = '{0, 0, 15, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      run_phase(cs, 200, 40000);
      repeat (4) begin
         scale         = $urandom_range(50, 5000);
         cs.weak_lvl   = 0 - int'($urandom_range(40, 110));
         cs.strong_lvl = cs.weak_lvl + int'($urandom_range(0, 30));
         if (cs.strong_lvl > 0) cs.strong_lvl = 0;
         cs.dead       = $urandom_range(1, 15);
         cs.settle     = $urandom_range(0, scale);
         cs.safety     = $urandom_range(scale * 5, scale * 60);
         cs.min_active = $urandom_range(0, scale * 4);
         cs.recovery   = $urandom_range(0, scale * 4);
         cs.resend     = $urandom_range(0, scale * 2);
         run_phase(cs, 210, scale);
      end

      req_valid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (5) @(negedge clock);
      if (mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
